// File: hw/rtl/ptpd_pkg.sv
// ----------------------------------------------------------------------------
// Pan/tilt PD tracker package
// Shared widths, reset values, register indexes and interface structs.
// ----------------------------------------------------------------------------
package ptpd_pkg;

   // Servo range and gain scaling.
   localparam int POSITION_MAX = 1000;
   localparam int GAIN_SHIFT   = 10;

   // Field widths.
   localparam int X_W      = 9;
   localparam int Y_W      = 8;
   localparam int GAIN_W   = 10;
   localparam int OUT_W    = 10;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   // Datapath widths of one axis lane.
   localparam int ERR_W  = 10;                  // error, signed
   localparam int DIFF_W = ERR_W + 1;           // error minus last error
   localparam int PT_W   = ERR_W + GAIN_W + 1;  // proportional term
   localparam int DT_W   = DIFF_W + GAIN_W + 1; // derivative term
   localparam int SUM_W  = DT_W + 1;            // weighted sum
   localparam int POS_W  = $clog2(POSITION_MAX + 1);
   localparam int NP_W   = ((POS_W > SUM_W) ? POS_W : SUM_W) + 2;

   // Reset values.
   localparam int POS_RESET         = 500;
   localparam int PAN_P_RESET       = 400;
   localparam int PAN_D_RESET       = 300;
   localparam int TILT_P_RESET      = 500;
   localparam int TILT_D_RESET      = 400;
   localparam int X_CENTER_RESET    = 160;
   localparam int Y_CENTER_RESET    = 100;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_PAN_P_GAIN  = 3'd0,
      REG_PAN_D_GAIN  = 3'd1,
      REG_TILT_P_GAIN = 3'd2,
      REG_TILT_D_GAIN = 3'd3,
      REG_X_CENTER    = 3'd4,
      REG_Y_CENTER    = 3'd5
   } ptpd_reg_idx_type;

   // Current configuration as seen by the datapath.
   typedef struct packed {
      logic [GAIN_W-1:0] pan_p_gain;
      logic [GAIN_W-1:0] pan_d_gain;
      logic [GAIN_W-1:0] tilt_p_gain;
      logic [GAIN_W-1:0] tilt_d_gain;
      logic [X_W-1:0]    x_center;
      logic [Y_W-1:0]    y_center;
   } ptpd_cfg_type;

   // Pipeline control from the top level to each lane.
   typedef struct packed {
      logic load;    // transaction accepted: form error, register products
      logic update;  // second stage moves: apply velocity to the position
      logic run;     // item in second stage had a previous error
   } ptpd_lane_ctl_type;

endpackage

// File: hw/rtl/ptpd_csr.sv
// ----------------------------------------------------------------------------
// Pan/tilt PD tracker configuration registers
// Holds the gains and the image center, written through the CSR channel.
// ----------------------------------------------------------------------------
module ptpd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ptpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptpd_pkg::CSR_DAT_W-1:0] csr_wdata,
   output ptpd_pkg::ptpd_cfg_type         cfg
);
   import ptpd_pkg::*;

   ptpd_cfg_type cfg_ff;
   ptpd_cfg_type cfg_in;
   logic         wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index)
            REG_PAN_P_GAIN:  cfg_in.pan_p_gain  = csr_wdata[GAIN_W-1:0];
            REG_PAN_D_GAIN:  cfg_in.pan_d_gain  = csr_wdata[GAIN_W-1:0];
            REG_TILT_P_GAIN: cfg_in.tilt_p_gain = csr_wdata[GAIN_W-1:0];
            REG_TILT_D_GAIN: cfg_in.tilt_d_gain = csr_wdata[GAIN_W-1:0];
            REG_X_CENTER:    cfg_in.x_center    = csr_wdata[X_W-1:0];
            REG_Y_CENTER:    cfg_in.y_center    = csr_wdata[Y_W-1:0];
            default:         cfg_in             = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pan_p_gain  <= GAIN_W'(PAN_P_RESET);
         cfg_ff.pan_d_gain  <= GAIN_W'(PAN_D_RESET);
         cfg_ff.tilt_p_gain <= GAIN_W'(TILT_P_RESET);
         cfg_ff.tilt_d_gain <= GAIN_W'(TILT_D_RESET);
         cfg_ff.x_center    <= X_W'(X_CENTER_RESET);
         cfg_ff.y_center    <= Y_W'(Y_CENTER_RESET);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/ptpd_axis_lane.sv
// ----------------------------------------------------------------------------
// Pan/tilt PD tracker axis lane
// Two-stage incremental PD update of one servo axis with clamping.
// ----------------------------------------------------------------------------
module ptpd_axis_lane (
   input  logic                              clock,
   input  logic                              reset,
   input  ptpd_pkg::ptpd_lane_ctl_type       ctl,
   input  logic signed [ptpd_pkg::ERR_W-1:0] err,
   input  logic [ptpd_pkg::GAIN_W-1:0]       p_gain,
   input  logic [ptpd_pkg::GAIN_W-1:0]       d_gain,
   output logic [ptpd_pkg::POS_W-1:0]        pos
);
   import ptpd_pkg::*;

   logic signed [ERR_W-1:0]  last_err_ff;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PT_W-1:0]   p_term_ff, p_term_in;
   logic signed [DT_W-1:0]   d_term_ff, d_term_in;
   logic signed [SUM_W-1:0]  sum;
   logic signed [SUM_W-1:0]  vel;
   logic signed [NP_W-1:0]   new_pos;
   logic [POS_W-1:0]         pos_ff, pos_in;

   // First stage: the two products, one multiplier each.
   assign diff      = DIFF_W'(err) - DIFF_W'(last_err_ff);
   assign p_term_in = $signed(err) * $signed({1'b0, p_gain});
   assign d_term_in = $signed(diff) * $signed({1'b0, d_gain});

   // Second stage: scale with floor, accumulate, clamp.
   assign sum     = SUM_W'(p_term_ff) + SUM_W'(d_term_ff);
   assign vel     = sum >>> GAIN_SHIFT;
   assign new_pos = NP_W'(vel) + $signed({{(NP_W-POS_W){1'b0}}, pos_ff});

   always_comb begin
      pos_in = pos_ff;
      if (ctl.update && ctl.run) begin
         priority if (new_pos[NP_W-1]) begin
            pos_in = '0;
         end else if (new_pos > $signed(NP_W'(POSITION_MAX))) begin
            pos_in = POS_W'(POSITION_MAX);
         end else begin
            pos_in = new_pos[POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         p_term_ff <= p_term_in;
         d_term_ff <= d_term_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_err_ff <= '0;
         pos_ff      <= POS_W'(POS_RESET);
      end else begin
         if (ctl.load) begin
            last_err_ff <= err;
         end
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

// File: hw/rtl/pan_tilt_pd_tracker_core.sv
// ----------------------------------------------------------------------------
// Pan/tilt PD tracker core
// Two-axis incremental PD controller turning target coordinates into servo
// position commands.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction (req_valid/req_ready) carries one target coordinate
//   pair. Each one produces exactly one response transaction (rsp_valid/
//   rsp_ready) with the clamped pan and tilt positions, in order.
//   The CSR channel writes the gains and the image center; it is always
//   ready and must only be used while no transaction is in flight.
//   With the response register free, an accepted request is registered in the
//   multiplier stage, and the accumulate stage then loads the response
//   register and raises rsp_valid. Throughput is one transaction per cycle
//   while the receiver keeps up: the pan and tilt lanes run side by side,
//   each with one multiplier stage and one accumulate stage, and the
//   accumulate stage closes the position loop.
//   When the receiver stalls, the response and the position it shows are
//   held; one more request is still taken into the multiplier stage, after
//   which req_ready drops until the response is consumed.
//   Reset returns both positions to servo center, clears the last errors and
//   the gains and center to their defaults. The first request after reset
//   only records the errors and reports the center positions.
// ----------------------------------------------------------------------------
module pan_tilt_pd_tracker_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [ptpd_pkg::X_W-1:0]       req_target_x,
   input  logic [ptpd_pkg::Y_W-1:0]       req_target_y,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [ptpd_pkg::OUT_W-1:0]     rsp_pan_position,
   output logic [ptpd_pkg::OUT_W-1:0]     rsp_tilt_position,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ptpd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ptpd_pkg::CSR_DAT_W-1:0] csr_wdata
);
   import ptpd_pkg::*;

   ptpd_cfg_type            cfg;
   ptpd_lane_ctl_type       ctl;
   logic                    accept;
   logic                    advance;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_run_ff;
   logic                    have_last_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [ERR_W-1:0] pan_err;
   logic signed [ERR_W-1:0] tilt_err;
   logic [POS_W-1:0]        pan_pos;
   logic [POS_W-1:0]        tilt_pos;

   ptpd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // The second stage moves whenever the response register is free or
   // being drained; the first stage takes a new transaction when it is
   // empty or moving on.
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = !s1_valid_ff || advance;
   assign accept    = req_valid && req_ready;

   assign ctl.load   = accept;
   assign ctl.update = s1_valid_ff && advance;
   assign ctl.run    = s1_run_ff;

   // Pan error is center minus target, tilt error is target minus center.
   assign pan_err  = ERR_W'({1'b0, cfg.x_center}) - ERR_W'({1'b0, req_target_x});
   assign tilt_err = ERR_W'({1'b0, req_target_y}) - ERR_W'({1'b0, cfg.y_center});

   ptpd_axis_lane u_pan_lane (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .err    (pan_err),
      .p_gain (cfg.pan_p_gain),
      .d_gain (cfg.pan_d_gain),
      .pos    (pan_pos)
   );

   ptpd_axis_lane u_tilt_lane (
      .clock  (clock),
      .reset  (reset),
      .ctl    (ctl),
      .err    (tilt_err),
      .p_gain (cfg.tilt_p_gain),
      .d_gain (cfg.tilt_d_gain),
      .pos    (tilt_pos)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (ctl.update) begin
         s1_valid_in = 1'b0;
      end
   end

   // Merge stage: the lane positions only change when a new response is
   // loaded, so they serve directly as the held response payload.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_run_ff    <= 1'b0;
         have_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            s1_run_ff    <= have_last_ff;
            have_last_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pan_position  = OUT_W'(pan_pos);
   assign rsp_tilt_position = OUT_W'(tilt_pos);

endmodule

// File: hw/rtl/ptpd_checker.sv
// ----------------------------------------------------------------------------
// Pan/tilt PD tracker port checker
// Watches the top-level ports for response and range rules.
// ----------------------------------------------------------------------------
module ptpd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ptpd_pkg::OUT_W-1:0] rsp_pan_position,
   input logic [ptpd_pkg::OUT_W-1:0] rsp_tilt_position
);
   import ptpd_pkg::*;

   // A stalled response keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pan_position)
         && $stable(rsp_tilt_position))
      else $error("response changed while stalled");

   // Positions stay inside the servo range.
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pan_position <= OUT_W'(POSITION_MAX))
         && (rsp_tilt_position <= OUT_W'(POSITION_MAX)))
      else $error("position beyond servo range");

   // Reset empties the response register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // With the response register draining, a new request is always taken.
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      req_valid && rsp_valid && rsp_ready |-> req_ready)
      else $error("request blocked while response drains");

   // A response cannot appear the cycle after reset without a request.
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response without request");

endmodule

bind pan_tilt_pd_tracker_core ptpd_checker u_ptpd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_pan_position  (rsp_pan_position),
   .rsp_tilt_position (rsp_tilt_position)
);

// File: bench/pan_tilt_pd_tracker_core_tb.sv
// ----------------------------------------------------------------------------
// Pan/tilt PD tracker core testbench
// Sends target coordinate transactions through the request channel and checks
// every response against a cycle-free model of the two PD loops kept in the
// bench. Gains and image center are rewritten between phases while the core
// is idle. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module pan_tilt_pd_tracker_core_tb;
   import ptpd_pkg::*;

   // Generous ceiling on run length, well above the slowest legal run.
   localparam int TIMEOUT_UNITS = 12 * 400000;
   localparam int DIRECTED_ROWS = 20;
   // Register indexes that decode to nothing; writes to them must be dropped.
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;

   // How the receiver paces rsp_ready during a phase.
   typedef enum int {RX_ALWAYS, RX_MOSTLY, RX_PATTERN, RX_SPARSE} rx_style_type;

   typedef struct packed {
      logic [OUT_W-1:0] pan;
      logic [OUT_W-1:0] tilt;
   } servo_cmd_type;

   typedef struct {
      logic [X_W-1:0]   tx;
      logic [Y_W-1:0]   ty;
      bit               typed;
      logic [OUT_W-1:0] want_pan;
      logic [OUT_W-1:0] want_tilt;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [X_W-1:0]       req_target_x = '0;
   logic [Y_W-1:0]       req_target_y = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [OUT_W-1:0]     rsp_pan_position;
   logic [OUT_W-1:0]     rsp_tilt_position;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   pan_tilt_pd_tracker_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_target_x      (req_target_x),
      .req_target_y      (req_target_y),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pan_position  (rsp_pan_position),
      .rsp_tilt_position (rsp_tilt_position),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // The bench's own copy of the configuration and of the loop state.
   ptpd_cfg_type tracker_cfg = '{
      pan_p_gain:  GAIN_W'(PAN_P_RESET),
      pan_d_gain:  GAIN_W'(PAN_D_RESET),
      tilt_p_gain: GAIN_W'(TILT_P_RESET),
      tilt_d_gain: GAIN_W'(TILT_D_RESET),
      x_center:    X_W'(X_CENTER_RESET),
      y_center:    Y_W'(Y_CENTER_RESET)
   };
   int pan_pos_model   = POS_RESET;
   int tilt_pos_model  = POS_RESET;
   int pan_err_model   = 0;
   int tilt_err_model  = 0;
   bit loop_primed     = 1'b0;

   // Servo commands predicted for accepted transactions, oldest first.
   servo_cmd_type pending_cmds [$];

   int           mismatch_count = 0;
   int           burst_left     = 0;
   int           holdoff_left   = 0;
   rx_style_type rx_style       = RX_MOSTLY;
   int           last_tx        = X_CENTER_RESET;
   int           last_ty        = Y_CENTER_RESET;

   // Directed opening. The first transaction after reset only records the
   // errors, so both servos report center. A target parked in the far corner
   // then drives pan to its lower stop and tilt to its upper stop within six
   // transactions under the reset gains. The remaining rows hit the field
   // extremes, out-of-range coordinates and alternating bit patterns, and are
   // checked against the model.
   directed_row_type directed_rows [DIRECTED_ROWS] = '{
      '{9'd160, 8'd100, 1'b1, 10'd500, 10'd500},
      '{9'd511, 8'd255, 1'b0, 10'd0,   10'd0},
      '{9'd511, 8'd255, 1'b0, 10'd0,   10'd0},
      '{9'd511, 8'd255, 1'b0, 10'd0,   10'd0},
      '{9'd511, 8'd255, 1'b0, 10'd0,   10'd0},
      '{9'd511, 8'd255, 1'b0, 10'd0,   10'd0},
      '{9'd511, 8'd255, 1'b1, 10'd0,   10'd1000},
      '{9'd0,   8'd0,   1'b0, 10'd0,   10'd0},
      '{9'd319, 8'd199, 1'b0, 10'd0,   10'd0},
      '{9'd0,   8'd199, 1'b0, 10'd0,   10'd0},
      '{9'd319, 8'd0,   1'b0, 10'd0,   10'd0},
      '{9'd511, 8'd0,   1'b0, 10'd0,   10'd0},
      '{9'd0,   8'd255, 1'b0, 10'd0,   10'd0},
      '{9'h155, 8'hAA,  1'b0, 10'd0,   10'd0},
      '{9'h0AA, 8'h55,  1'b0, 10'd0,   10'd0},
      '{9'd256, 8'd128, 1'b0, 10'd0,   10'd0},
      '{9'd160, 8'd100, 1'b0, 10'd0,   10'd0},
      '{9'd160, 8'd100, 1'b0, 10'd0,   10'd0},
      '{9'd1,   8'd1,     1'b0, 10'd0,   10'd0},
      '{9'd170, 8'd90,  1'b0, 10'd0,   10'd0}
   };

   // One axis of the incremental PD loop. The arithmetic right shift of a
   // signed int rounds toward minus infinity, which is what the core does.
   function automatic int step_axis(input int pos, input int err, input int last_err,
                                    input int p_gain, input int d_gain);
      int weighted;
      int next_pos;
      weighted = err * p_gain + (err - last_err) * d_gain;
      next_pos = pos + (weighted >>> GAIN_SHIFT);
      if (next_pos > POSITION_MAX) begin
         next_pos = POSITION_MAX;
      end else if (next_pos < 0) begin
         next_pos = 0;
      end
      return next_pos;
   endfunction

   // Advances the loop model by one target and returns the servo command.
   function automatic servo_cmd_type track_target(input logic [X_W-1:0] tx,
                                                  input logic [Y_W-1:0] ty);
      int pan_err;
      int tilt_err;
      servo_cmd_type cmd;
      pan_err  = int'(tracker_cfg.x_center) - int'(tx);
      tilt_err = int'(ty) - int'(tracker_cfg.y_center);
      if (loop_primed) begin
         pan_pos_model  = step_axis(pan_pos_model, pan_err, pan_err_model,
                                    int'(tracker_cfg.pan_p_gain),
                                    int'(tracker_cfg.pan_d_gain));
         tilt_pos_model = step_axis(tilt_pos_model, tilt_err, tilt_err_model,
                                    int'(tracker_cfg.tilt_p_gain),
                                    int'(tracker_cfg.tilt_d_gain));
      end
      pan_err_model  = pan_err;
      tilt_err_model = tilt_err;
      loop_primed    = 1'b1;
      cmd.pan  = pan_pos_model[OUT_W-1:0];
      cmd.tilt = tilt_pos_model[OUT_W-1:0];
      return cmd;
   endfunction

   function automatic int clip(input int v, input int hi);
      return (v < 0) ? 0 : ((v > hi) ? hi : v);
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH @%0t: %s got %0d, expected %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // Holds one request transaction until it is accepted, then records what
   // the core must answer. A typed expectation overrides the model's.
   task automatic offer_target(input logic [X_W-1:0] tx, input logic [Y_W-1:0] ty,
                               input bit typed, input servo_cmd_type want);
      servo_cmd_type cmd;
      req_valid    <= 1'b1;
      req_target_x <= tx;
      req_target_y <= ty;
      do @(posedge clock); while (!req_ready);
      cmd = track_target(tx, ty);
      if (typed) begin
         cmd = want;
      end
      pending_cmds.push_back(cmd);
   endtask

   // Sender pacing: bursts of random length separated by random gaps. With a
   // zero gap bound the sender offers back to back.
   task automatic pace_sender(input int max_gap);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, max_gap);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stops sending and waits until every outstanding response is back, then
   // lets the two-stage pipeline settle.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_cmds.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Register writes stay back to back; valid drops once after the last one.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_PAN_P_GAIN:  tracker_cfg.pan_p_gain  = data[GAIN_W-1:0];
         REG_PAN_D_GAIN:  tracker_cfg.pan_d_gain  = data[GAIN_W-1:0];
         REG_TILT_P_GAIN: tracker_cfg.tilt_p_gain = data[GAIN_W-1:0];
         REG_TILT_D_GAIN: tracker_cfg.tilt_d_gain = data[GAIN_W-1:0];
         REG_X_CENTER:    tracker_cfg.x_center    = data[X_W-1:0];
         REG_Y_CENTER:    tracker_cfg.y_center    = data[Y_W-1:0];
         default: ;
      endcase
   endtask

   // Writes every register, then both undecoded indexes with random data,
   // which must leave the configuration untouched.
   task automatic load_settings(input int pan_p, input int pan_d, input int tilt_p,
                                input int tilt_d, input int x_ctr, input int y_ctr);
      write_csr(REG_PAN_P_GAIN,  CSR_DAT_W'(pan_p));
      write_csr(REG_PAN_D_GAIN,  CSR_DAT_W'(pan_d));
      write_csr(REG_TILT_P_GAIN, CSR_DAT_W'(tilt_p));
      write_csr(REG_TILT_D_GAIN, CSR_DAT_W'(tilt_d));
      write_csr(REG_X_CENTER,    CSR_DAT_W'(x_ctr));
      write_csr(REG_Y_CENTER,    CSR_DAT_W'(y_ctr));
      write_csr(REG_SPARE_A,     CSR_DAT_W'($urandom_range(0, 1023)));
      write_csr(REG_SPARE_B,     CSR_DAT_W'($urandom_range(0, 1023)));
      csr_valid <= 1'b0;
   endtask

   // One phase of random targets. Most targets sit near the image center or
   // wander from the previous one, the way a tracked object moves, so the
   // servos spend time away from their stops. The rest jump anywhere in the
   // image or use the raw field range beyond it.
   task automatic run_phase(input int n_items, input int max_gap, input rx_style_type style,
                            input bit squeeze, input bit pause);
      int i;
      int pick;
      servo_cmd_type unused;
      unused   = '0;
      rx_style = style;
      for (i = 0; i < n_items; i++) begin
         // Long receiver hold-off while the sender keeps offering, so the
         // pipeline fills and req_ready has to drop.
         if (squeeze && i == 40) begin
            holdoff_left = 64;
            burst_left   = 16;
         end
         // Sender pause until every response is back, mid phase.
         if (pause && i == n_items / 2) begin
            drain_and_settle();
         end
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            last_tx = clip(int'(tracker_cfg.x_center) + $urandom_range(0, 48) - 24, 511);
            last_ty = clip(int'(tracker_cfg.y_center) + $urandom_range(0, 48) - 24, 255);
         end else if (pick < 70) begin
            last_tx = clip(last_tx + $urandom_range(0, 16) - 8, 319);
            last_ty = clip(last_ty + $urandom_range(0, 16) - 8, 199);
         end else if (pick < 85) begin
            last_tx = $urandom_range(0, 319);
            last_ty = $urandom_range(0, 199);
         end else begin
            last_tx = $urandom_range(0, 511);
            last_ty = $urandom_range(0, 255);
         end
         pace_sender(max_gap);
         offer_target(X_W'(last_tx), Y_W'(last_ty), 1'b0, unused);
      end
   endtask

   // Receiver: an optional long hold-off counted here, otherwise a stall
   // pattern that depends on the phase.
   initial begin
      int pattern_step;
      pattern_step = 0;
      forever begin
         @(posedge clock);
         pattern_step++;
         if (holdoff_left > 0) begin
            holdoff_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (rx_style)
               RX_ALWAYS:  rsp_ready <= 1'b1;
               RX_MOSTLY:  rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_PATTERN: rsp_ready <= ((pattern_step % 7) < 4);
               default:    rsp_ready <= ($urandom_range(0, 9) < 3);
            endcase
         end
      end
   end

   // Response checker: every accepted response transaction is matched
   // against the oldest outstanding prediction.
   always @(posedge clock) begin
      servo_cmd_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_cmds.size() == 0) begin
            report_mismatch("response with nothing outstanding, pan_position",
                            int'(rsp_pan_position), 0);
         end else begin
            want = pending_cmds.pop_front();
            if (rsp_pan_position !== want.pan) begin
               report_mismatch("pan_position", int'(rsp_pan_position), int'(want.pan));
            end
            if (rsp_tilt_position !== want.tilt) begin
               report_mismatch("tilt_position", int'(rsp_tilt_position),
                               int'(want.tilt));
            end
         end
      end
   end

   initial begin
      #(TIMEOUT_UNITS);
      $display("pan_tilt_pd_tracker_core_tb NOT OK");
      $finish;
   end

   initial begin
      int i;
      servo_cmd_type want;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed targets under the reset configuration.
      for (i = 0; i < DIRECTED_ROWS; i++) begin
         want.pan  = directed_rows[i].want_pan;
         want.tilt = directed_rows[i].want_tilt;
         pace_sender(3);
         offer_target(directed_rows[i].tx, directed_rows[i].ty, directed_rows[i].typed, want);
      end

      // All gains zero and the center in the corner: the servos must freeze.
      drain_and_settle();
      load_settings(0, 0, 0, 0, 0, 0);
      run_phase(215, 4, RX_MOSTLY, 1'b0, 1'b0);

      // All gains at full scale; the center words carry bits above the
      // register widths, which the core drops.
      drain_and_settle();
      load_settings(1023, 1023, 1023, 1023, 1023, 1023);
      run_phase(215, 0, RX_ALWAYS, 1'b0, 1'b0);

      // Random gains, center at the far edge of the image.
      drain_and_settle();
      load_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023), 319, 199);
      run_phase(215, 2, RX_PATTERN, 1'b0, 1'b0);

      // Small gains keep the positions away from the stops; long hold-off.
      drain_and_settle();
      load_settings($urandom_range(1, 48), $urandom_range(1, 48),
                    $urandom_range(1, 48), $urandom_range(1, 48),
                    $urandom_range(100, 220), $urandom_range(60, 140));
      run_phase(215, 2, RX_ALWAYS, 1'b1, 1'b0);

      // Everything random over the whole write word, sparse receiver.
      drain_and_settle();
      load_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023));
      run_phase(215, 6, RX_SPARSE, 1'b0, 1'b0);

      // Back to the reset values, with a sender pause mid phase.
      drain_and_settle();
      load_settings(PAN_P_RESET, PAN_D_RESET, TILT_P_RESET, TILT_D_RESET,
                    X_CENTER_RESET, Y_CENTER_RESET);
      run_phase(215, 3, RX_MOSTLY, 1'b0, 1'b1);

      // Random again, with a second hold-off.
      drain_and_settle();
      load_settings($urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023), $urandom_range(0, 1023));
      run_phase(215, 5, RX_PATTERN, 1'b1, 1'b0);

      drain_and_settle();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0 && pending_cmds.size() == 0) begin
         $display("pan_tilt_pd_tracker_core_tb OK");
      end else begin
         $display("pan_tilt_pd_tracker_core_tb NOT OK");
      end
      $finish;
   end

endmodule
